// ===== hdl/packed_sprite_decoder_defines.svh =====
// Assertion macros for the packed sprite decoder.
`ifndef PACKED_SPRITE_DECODER_DEFINES_SVH
`define PACKED_SPRITE_DECODER_DEFINES_SVH

`ifndef SYNTH

`define PSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PSD_ASSERT_SAME(lbl, ante, cons, msg)

`define PSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/psd_pkg.sv =====
// Shared types, constants and tables of the packed sprite decoder.
`timescale 1ns / 1ps

package psd_pkg;

  localparam int ROW_STRIDE = 320;

  localparam logic [2:0] CFG_START_POSITION = 3'd0;
  localparam logic [2:0] CFG_COLOR_ONE      = 3'd1;
  localparam logic [2:0] CFG_COLOR_TWO      = 3'd2;
  localparam logic [2:0] CFG_CLEAR_ZERO     = 3'd3;
  localparam logic [2:0] CFG_RAW_BYTES      = 3'd4;

  localparam logic [2:0] HDR_KIND       = 3'd0;
  localparam logic [2:0] HDR_WIDTH      = 3'd1;
  localparam logic [2:0] HDR_WIDTH_EXT  = 3'd2;
  localparam logic [2:0] HDR_HEIGHT     = 3'd3;
  localparam logic [2:0] HDR_HEIGHT_EXT = 3'd4;
  localparam logic [2:0] HDR_DATA       = 3'd5;

  localparam logic [1:0] KIND_TERNARY = 2'd0;
  localparam logic [1:0] KIND_BIN_TWO = 2'd2;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_image;
  } psd_in_t;

  typedef struct packed {
    logic [15:0] pixel_address;
    logic [31:0] pixel_value;
    logic        write_enable;
    logic        image_end;
    logic        last_of_item;
  } psd_out_t;

  typedef struct packed {
    logic load;
    logic emit;
  } psd_cmd_t;

  typedef struct packed {
    logic go;
    logic slot_free;
    logic emit_last;
  } psd_sts_t;

  function automatic logic [7:0] printable(input logic [7:0] b);
    logic [7:0] t;
    begin
      t = (b >= 8'd92) ? b - 8'd1 : b;
      printable = t - 8'd35;
    end
  endfunction

  function automatic logic [5:0] digit_weight(input logic [1:0] kind, input logic [2:0] idx);
    begin
      if (kind == KIND_TERNARY) begin
        case (idx)
          3'd0:    digit_weight = 6'd27;
          3'd1:    digit_weight = 6'd9;
          3'd2:    digit_weight = 6'd3;
          default: digit_weight = 6'd1;
        endcase
      end else begin
        case (idx)
          3'd0:    digit_weight = 6'd32;
          3'd1:    digit_weight = 6'd16;
          3'd2:    digit_weight = 6'd8;
          3'd3:    digit_weight = 6'd4;
          3'd4:    digit_weight = 6'd2;
          default: digit_weight = 6'd1;
        endcase
      end
    end
  endfunction

  function automatic logic [2:0] digit_total(input logic [1:0] kind);
    begin
      digit_total = (kind == KIND_TERNARY) ? 3'd4 : 3'd6;
    end
  endfunction

endpackage

// ===== hdl/psd_ctrl.sv =====
// Controller state machine of the packed sprite decoder.
`timescale 1ns / 1ps

module psd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psd_pkg::psd_sts_t sts,
  output psd_pkg::psd_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } psd_state_t;

  psd_state_t state_r, state_nxt;

  always_comb begin
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    in_stall  = 1'b1;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.go) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/psd_datapath.sv =====
// Datapath of the packed sprite decoder: configuration, header state, pixel unit, output register.
`timescale 1ns / 1ps

module psd_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  psd_pkg::psd_in_t   in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output psd_pkg::psd_out_t  out_data,
  input  psd_pkg::psd_cmd_t  cmd,
  output psd_pkg::psd_sts_t  sts
);

  logic [15:0] start_pos_r;
  logic [23:0] color_one_r;
  logic [23:0] color_two_r;
  logic        clear_zero_r;
  logic        raw_bytes_r;

  logic [7:0]  byte_r, byte_nxt;
  logic        raw_item_r, raw_item_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [10:0] width_r, width_nxt;
  logic [10:0] height_r, height_nxt;
  logic [10:0] col_r, col_nxt;
  logic [10:0] row_r, row_nxt;
  logic [15:0] wp_r, wp_nxt;
  logic [2:0]  digit_r, digit_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic        done_r, done_nxt;
  psd_pkg::psd_out_t out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [7:0]  dec;
  logic [5:0]  wgt;
  logic [8:0]  m1, m2, m3, m4, msel;
  logic [8:0]  rem_w;
  logic [2:0]  quot;
  logic [2:0]  trit;
  logic        digit_bit;
  logic [7:0]  pix_code;
  logic [11:0] col_inc;
  logic [11:0] row_inc;
  logic        row_wrap;
  logic        img_end;
  logic [2:0]  digit_inc;
  logic        digits_done;
  logic        go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r  <= '0;
      color_one_r  <= '0;
      color_two_r  <= '0;
      clear_zero_r <= 1'b0;
      raw_bytes_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        psd_pkg::CFG_START_POSITION: start_pos_r  <= cfg_data[15:0];
        psd_pkg::CFG_COLOR_ONE:      color_one_r  <= cfg_data;
        psd_pkg::CFG_COLOR_TWO:      color_two_r  <= cfg_data;
        psd_pkg::CFG_CLEAR_ZERO:     clear_zero_r <= cfg_data[0];
        psd_pkg::CFG_RAW_BYTES:      raw_bytes_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Pixel unit: one digit of the held code per beat, most significant first.
  always_comb begin
    wgt   = psd_pkg::digit_weight(kind_r, digit_r);
    m1    = {3'b0, wgt};
    m2    = {2'b0, wgt, 1'b0};
    m3    = m1 + m2;
    m4    = {1'b0, wgt, 2'b0};
    rem_w = {2'b0, rem_r};
    if (rem_w >= m4) begin
      quot = 3'd4;
      msel = m4;
    end else if (rem_w >= m3) begin
      quot = 3'd3;
      msel = m3;
    end else if (rem_w >= m2) begin
      quot = 3'd2;
      msel = m2;
    end else if (rem_w >= m1) begin
      quot = 3'd1;
      msel = m1;
    end else begin
      quot = 3'd0;
      msel = '0;
    end
    trit      = (quot >= 3'd3) ? quot - 3'd3 : quot;
    digit_bit = quot[0];
    if (raw_item_r) begin
      pix_code = byte_r;
    end else if (kind_r == psd_pkg::KIND_TERNARY) begin
      pix_code = {5'b0, trit};
    end else if (kind_r == psd_pkg::KIND_BIN_TWO) begin
      pix_code = {6'b0, digit_bit, 1'b0};
    end else begin
      pix_code = {7'b0, digit_bit};
    end
    col_inc     = {1'b0, col_r} + 12'd1;
    row_inc     = {1'b0, row_r} + 12'd1;
    row_wrap    = col_inc >= {1'b0, width_r};
    img_end     = row_wrap && (row_inc >= {1'b0, height_r});
    digit_inc   = digit_r + 3'd1;
    digits_done = digit_inc >= psd_pkg::digit_total(kind_r);
  end

  always_comb begin
    byte_nxt      = byte_r;
    raw_item_nxt  = raw_item_r;
    step_nxt      = step_r;
    kind_nxt      = kind_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    wp_nxt        = wp_r;
    digit_nxt     = digit_r;
    rem_nxt       = rem_r;
    done_nxt      = done_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    go            = 1'b0;
    dec           = psd_pkg::printable(in_data.code_byte);

    if (cmd.load) begin
      byte_nxt     = in_data.code_byte;
      raw_item_nxt = raw_bytes_r;
      if (in_data.start_image) begin
        step_nxt   = psd_pkg::HDR_KIND;
        kind_nxt   = '0;
        width_nxt  = '0;
        height_nxt = '0;
        col_nxt    = '0;
        row_nxt    = '0;
        digit_nxt  = '0;
        rem_nxt    = '0;
        wp_nxt     = start_pos_r;
        done_nxt   = 1'b0;
      end
      if (!done_nxt) begin
        if (raw_bytes_r) begin
          if (step_nxt <= psd_pkg::HDR_WIDTH_EXT) begin
            width_nxt = {3'b0, in_data.code_byte};
            step_nxt  = psd_pkg::HDR_HEIGHT;
          end else if (step_nxt <= psd_pkg::HDR_HEIGHT_EXT) begin
            height_nxt = {3'b0, in_data.code_byte};
            step_nxt   = psd_pkg::HDR_DATA;
            col_nxt    = '0;
            row_nxt    = '0;
            digit_nxt  = '0;
            done_nxt   = (width_nxt == '0) || (height_nxt == '0);
          end else begin
            go = 1'b1;
          end
        end else begin
          case (step_nxt)
            psd_pkg::HDR_KIND: begin
              if (dec > 8'd2) begin
                done_nxt = 1'b1;
              end else begin
                kind_nxt = dec[1:0];
                step_nxt = psd_pkg::HDR_WIDTH;
              end
            end
            psd_pkg::HDR_WIDTH: begin
              width_nxt = {3'b0, dec};
              step_nxt  = (dec > 8'd63) ? psd_pkg::HDR_WIDTH_EXT : psd_pkg::HDR_HEIGHT;
            end
            psd_pkg::HDR_WIDTH_EXT: begin
              width_nxt = {width_nxt[4:0], 6'b0} + {3'b0, dec};
              step_nxt  = psd_pkg::HDR_HEIGHT;
            end
            psd_pkg::HDR_HEIGHT: begin
              height_nxt = {3'b0, dec};
              if (dec > 8'd63) begin
                step_nxt = psd_pkg::HDR_HEIGHT_EXT;
              end else begin
                step_nxt  = psd_pkg::HDR_DATA;
                col_nxt   = '0;
                row_nxt   = '0;
                digit_nxt = '0;
                done_nxt  = (width_nxt == '0) || (height_nxt == '0);
              end
            end
            psd_pkg::HDR_HEIGHT_EXT: begin
              height_nxt = {height_nxt[4:0], 6'b0} + {3'b0, dec};
              step_nxt   = psd_pkg::HDR_DATA;
              col_nxt    = '0;
              row_nxt    = '0;
              digit_nxt  = '0;
              done_nxt   = (width_nxt == '0) || (height_nxt == '0);
            end
            default: begin
              go        = 1'b1;
              rem_nxt   = dec[6:0];
              digit_nxt = '0;
            end
          endcase
        end
      end
    end

    if (cmd.emit) begin
      out_valid_nxt             = 1'b1;
      out_nxt.pixel_address     = wp_r;
      out_nxt.pixel_value       = '0;
      if (pix_code != '0) begin
        out_nxt.pixel_value = {8'hFF, (pix_code > 8'd1) ? color_two_r : color_one_r};
      end
      out_nxt.write_enable      = (pix_code != '0) || clear_zero_r;
      out_nxt.image_end         = img_end;
      out_nxt.last_of_item      = raw_item_r || img_end || digits_done;
      if (!raw_item_r) begin
        rem_nxt   = 7'(rem_w - msel);
        digit_nxt = digits_done ? '0 : digit_inc;
      end
      if (row_wrap) begin
        col_nxt = '0;
        row_nxt = row_inc[10:0];
        wp_nxt  = wp_r + 16'(psd_pkg::ROW_STRIDE + 1) - {5'b0, width_r};
      end else begin
        col_nxt = col_inc[10:0];
        wp_nxt  = wp_r + 16'd1;
      end
      if (img_end) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= psd_pkg::HDR_KIND;
      kind_r      <= '0;
      width_r     <= '0;
      height_r    <= '0;
      col_r       <= '0;
      row_r       <= '0;
      wp_r        <= '0;
      digit_r     <= '0;
      rem_r       <= '0;
      done_r      <= 1'b1;
      raw_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      kind_r      <= kind_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      wp_r        <= wp_nxt;
      digit_r     <= digit_nxt;
      rem_r       <= rem_nxt;
      done_r      <= done_nxt;
      raw_item_r  <= raw_item_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.go        = go;
  assign sts.slot_free = !out_valid_r || !out_stall;
  assign sts.emit_last = raw_item_r || img_end || digits_done;

endmodule

// ===== hdl/packed_sprite_decoder.sv =====
// Top level of the packed sprite decoder.
`timescale 1ns / 1ps

`include "packed_sprite_decoder_defines.svh"

// Turns a sprite code stream, one byte per beat, into pixel writes for a frame buffer
// with a 320-pixel row stride. A header byte is taken while the block stays idle. A data
// byte is taken while idle and then gives one pixel beat per cycle from the output
// register while the output is not stalled: one pixel in raw mode, four for a ternary
// code and six for a six-bit code, fewer when the sprite ends inside the code. The next
// byte is taken as soon as the last pixel of the current one sits in the output register.
// Configuration is to be written only while the block is idle, which it does not enforce.
module packed_sprite_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  psd_pkg::psd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output psd_pkg::psd_out_t out_data
);

  psd_pkg::psd_cmd_t cmd;
  psd_pkg::psd_sts_t sts;

  psd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  `PSD_ASSERT_SAME(a_emit_only_busy, cmd.emit, in_stall, "pixel emitted while idle")
  `PSD_ASSERT_NEXT(a_emit_fills_out, cmd.emit, out_valid, "emitted pixel not held")
  `PSD_ASSERT_NEXT(a_last_frees_in, cmd.emit && sts.emit_last, !in_stall, "no return to idle")
  `PSD_ASSERT_NEXT(a_header_one_cycle, cmd.load && !sts.go, !in_stall, "header beat held")

endmodule
